/* sv/gda_pkg.sv */
// gda_pkg: shared types, constants and calendar tables for the gregorian date unit
// no dependencies; used by every module of the block
package gda_pkg;

    // pipeline layout: three stages per day-number converter, one join stage,
    // seven stages back to a civil date, one output register
    localparam int NUM_STAGES = 12;
    localparam int DN_STAGES  = 3;
    localparam int JOIN_STAGE = 3;
    localparam int CIV_STAGES = 7;
    localparam int OUT_STAGE  = 11;

    // item command codes
    typedef enum logic {
        CMD_SHIFT = 1'b0,
        CMD_DIFF  = 1'b1
    } t_command;

    // field and internal widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 23;
    localparam int DAYNUM_W = 23;
    localparam int Z_W      = 24;
    localparam int DOE_W    = 18;
    localparam int ERA_W    = 7;
    localparam int YOE_W    = 9;
    localparam int DOY_W    = 9;

    // calendar constants
    localparam int unsigned   DAYS_PER_ERA = 146097;
    localparam logic [17:0]   CENTURY_DAYS = 18'd36524;
    localparam logic [14:0]   YEAR_BIAS    = 15'd400;
    localparam logic [Z_W-1:0] SHIFT_BASE  = Z_W'(30 * 146097);
    localparam logic signed [16:0] YEAR_REBASE = 17'sd12400;
    localparam logic [3:0]    MP_JANUARY   = 4'd10;

    // exact reciprocals: k = ceil(2^sh / d), sh = input bits + ceil(log2 d)
    localparam int DIV100_SH  = 22;
    localparam logic [15:0] DIV100_K =
        16'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
    localparam int ERA_SH     = 42;
    localparam logic [24:0] ERA_K =
        25'(((64'd1 << ERA_SH) + 64'd146096) / 64'd146097);
    localparam int DIV1460_SH = 29;
    localparam logic [18:0] DIV1460_K =
        19'(((64'd1 << DIV1460_SH) + 64'd1459) / 64'd1460);
    localparam int DIV365_SH  = 27;
    localparam logic [18:0] DIV365_K =
        19'(((64'd1 << DIV365_SH) + 64'd364) / 64'd365);

    // month index counted from march, month field saturated to 1..12
    function automatic logic [3:0] march_month(input logic [3:0] month);
        logic [3:0] mp;
        unique case (month)
            4'd0, 4'd1:          mp = 4'd10;
            4'd2:                mp = 4'd11;
            4'd3:                mp = 4'd0;
            4'd4:                mp = 4'd1;
            4'd5:                mp = 4'd2;
            4'd6:                mp = 4'd3;
            4'd7:                mp = 4'd4;
            4'd8:                mp = 4'd5;
            4'd9:                mp = 4'd6;
            4'd10:               mp = 4'd7;
            4'd11:               mp = 4'd8;
            4'd12, 4'd13, 4'd14, 4'd15: mp = 4'd9;
        endcase
        return mp;
    endfunction

    // first day of a march-based month within its year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] ms;
        unique case (mp)
            4'd0:    ms = 9'd0;
            4'd1:    ms = 9'd31;
            4'd2:    ms = 9'd61;
            4'd3:    ms = 9'd92;
            4'd4:    ms = 9'd122;
            4'd5:    ms = 9'd153;
            4'd6:    ms = 9'd184;
            4'd7:    ms = 9'd214;
            4'd8:    ms = 9'd245;
            4'd9:    ms = 9'd275;
            4'd10:   ms = 9'd306;
            4'd11:   ms = 9'd337;
            default: ms = 9'd0;
        endcase
        return ms;
    endfunction

endpackage

/* sv/gda_pipe_ctrl.sv */
// gda_pipe_ctrl: valid bits and per-stage load enables of the date pipeline
// depends on gda_pkg
module gda_pipe_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gda_pkg::NUM_STAGES-1:0] o_load
);

    localparam logic [gda_pkg::NUM_STAGES-1:0] ALL_ONES = '1;

    logic [gda_pkg::NUM_STAGES-1:0] r_valid;
    logic [gda_pkg::NUM_STAGES-1:0] n_valid;

    // a stage may load when it or any stage after it is empty, or the sink takes
    always_comb begin
        for (int k = 0; k < gda_pkg::NUM_STAGES; k++) begin
            o_load[k] = i_out_ready || ((r_valid | ~(ALL_ONES << k)) != ALL_ONES);
        end
    end

    // valid bits move with the data
    always_comb begin
        n_valid[0] = o_load[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < gda_pkg::NUM_STAGES; k++) begin
            n_valid[k] = o_load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = o_load[0];
    assign o_out_valid = r_valid[gda_pkg::NUM_STAGES-1];

endmodule

/* sv/gda_day_number.sv */
// gda_day_number: three-stage conversion of a date to a linear day number
// depends on gda_pkg
module gda_day_number (
    input  logic                          i_clk,
    input  logic [gda_pkg::DN_STAGES-1:0] i_load,
    input  logic [gda_pkg::YEAR_W-1:0]    i_year,
    input  logic [gda_pkg::MONTH_W-1:0]   i_month,
    input  logic [gda_pkg::DAY_W-1:0]     i_day,
    output logic [gda_pkg::DAYNUM_W-1:0]  o_day_number
);

    logic [3:0]          w_mp;
    logic                w_jan_feb;
    logic [14:0]         n_y;
    logic signed [9:0]   n_doy;
    logic [14:0]         r_y;
    logic signed [9:0]   r_doy;

    logic [30:0]         w_prod100;
    logic [22:0]         n_y365;
    logic [22:0]         r_y365;
    logic [12:0]         r_q4;
    logic [7:0]          r_q100;
    logic signed [9:0]   r1_doy;

    logic signed [23:0]  n_dn;
    logic [22:0]         r_dn;

    // stage 0: year shifted so march starts the year, day within that year
    assign w_mp      = gda_pkg::march_month(i_month);
    assign w_jan_feb = (w_mp >= gda_pkg::MP_JANUARY);
    assign n_y       = {1'b0, i_year} + gda_pkg::YEAR_BIAS - {14'b0, w_jan_feb};
    assign n_doy     = $signed({1'b0, gda_pkg::month_start(w_mp)})
                     + $signed({5'b0, i_day}) - 10'sd1;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_y   <= n_y;
            r_doy <= n_doy;
        end
    end

    // stage 1: days in whole years and century count by reciprocal multiply
    assign w_prod100 = 31'(r_y) * 31'(gda_pkg::DIV100_K);
    assign n_y365    = 23'({8'b0, r_y} * 23'd365);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_y365 <= n_y365;
            r_q4   <= r_y[14:2];
            r_q100 <= w_prod100[gda_pkg::DIV100_SH +: 8];
            r1_doy <= r_doy;
        end
    end

    // stage 2: leap-day corrections and sum
    assign n_dn = $signed({1'b0, r_y365}) + $signed({11'b0, r_q4})
                - $signed({16'b0, r_q100}) + $signed({18'b0, r_q100[7:2]})
                + 24'(r1_doy);

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_dn <= n_dn[22:0];
        end
    end

    assign o_day_number = r_dn;

endmodule

/* sv/gda_civil_date.sv */
// gda_civil_date: seven-stage conversion of a biased day number back to a date
// depends on gda_pkg
module gda_civil_date (
    input  logic                           i_clk,
    input  logic [gda_pkg::CIV_STAGES-1:0] i_load,
    input  logic [gda_pkg::Z_W-1:0]        i_z,
    output logic [gda_pkg::YEAR_W-1:0]     o_year,
    output logic [gda_pkg::MONTH_W-1:0]    o_month,
    output logic [gda_pkg::DAY_W-1:0]      o_day,
    output logic                           o_out_of_range
);

    localparam int EW = gda_pkg::ERA_W;

    // stage registers
    logic [gda_pkg::Z_W-1:0]   r4_z;
    logic [EW-1:0]             r4_era, r5_era, r6_era, r7_era, r8_era, r9_era, r10_era;
    logic [gda_pkg::DOE_W-1:0] r5_doe, r6_doe, r7_doe, r8_doe;
    logic [6:0]                r6_q1460;
    logic [2:0]                r6_qcent;
    logic                      r6_last;
    logic [17:0]               r7_t;
    logic [gda_pkg::YOE_W-1:0] r8_yoe, r9_yoe, r10_yoe;
    logic [gda_pkg::DOY_W-1:0] r9_doy, r10_doy;
    logic [3:0]                r10_mp;

    // next values and products
    logic [48:0]               w_era_prod;
    logic [23:0]               w_era_days;
    logic [gda_pkg::DOE_W-1:0] n5_doe;
    logic [36:0]               w_p1460;
    logic [2:0]                n6_qcent;
    logic [17:0]               n7_t;
    logic [36:0]               w_p365;
    logic [1:0]                w_cent;
    logic [17:0]               w_year_days;
    logic [gda_pkg::DOY_W-1:0] n9_doy;
    logic [3:0]                n10_mp;

    // stage 4: 400-year era of the day number
    assign w_era_prod = 49'(i_z) * 49'(gda_pkg::ERA_K);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r4_z   <= i_z;
            r4_era <= w_era_prod[gda_pkg::ERA_SH +: EW];
        end
    end

    // stage 5: day within the era
    assign w_era_days = 24'({17'b0, r4_era} * 24'(gda_pkg::DAYS_PER_ERA));
    assign n5_doe     = 18'(r4_z - w_era_days);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r5_doe <= n5_doe;
            r5_era <= r4_era;
        end
    end

    // stage 6: four-year, century and era-end corrections
    assign w_p1460  = 37'(r5_doe) * 37'(gda_pkg::DIV1460_K);
    assign n6_qcent = 3'(r5_doe >= gda_pkg::CENTURY_DAYS)
                    + 3'(r5_doe >= 18'(2 * gda_pkg::CENTURY_DAYS))
                    + 3'(r5_doe >= 18'(3 * gda_pkg::CENTURY_DAYS))
                    + 3'(r5_doe >= 18'(4 * gda_pkg::CENTURY_DAYS));

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r6_q1460 <= w_p1460[gda_pkg::DIV1460_SH +: 7];
            r6_qcent <= n6_qcent;
            r6_last  <= (r5_doe == 18'(4 * gda_pkg::CENTURY_DAYS));
            r6_doe   <= r5_doe;
            r6_era   <= r5_era;
        end
    end

    // stage 7: day count with leap days removed
    assign n7_t = r6_doe - 18'(r6_q1460) + 18'(r6_qcent) - 18'(r6_last);

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r7_t   <= n7_t;
            r7_doe <= r6_doe;
            r7_era <= r6_era;
        end
    end

    // stage 8: year of the era
    assign w_p365 = 37'(r7_t) * 37'(gda_pkg::DIV365_K);

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r8_yoe <= w_p365[gda_pkg::DIV365_SH +: gda_pkg::YOE_W];
            r8_doe <= r7_doe;
            r8_era <= r7_era;
        end
    end

    // stage 9: day within the march-based year
    assign w_cent      = 2'(r8_yoe >= 9'd100) + 2'(r8_yoe >= 9'd200)
                       + 2'(r8_yoe >= 9'd300);
    assign w_year_days = 18'({9'b0, r8_yoe} * 18'd365) + 18'(r8_yoe[8:2])
                       - 18'(w_cent);
    assign n9_doy      = 9'(r8_doe - w_year_days);

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            r9_doy <= n9_doy;
            r9_yoe <= r8_yoe;
            r9_era <= r8_era;
        end
    end

    // stage 10: month by comparing against month starts
    always_comb begin
        n10_mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r9_doy >= gda_pkg::month_start(4'(i))) begin
                n10_mp = n10_mp + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[6]) begin
            r10_mp  <= n10_mp;
            r10_doy <= r9_doy;
            r10_yoe <= r9_yoe;
            r10_era <= r9_era;
        end
    end

    // final date fields, registered by the output stage
    logic                w_jan_feb;
    logic [16:0]         w_year_u;
    logic signed [16:0]  w_year;
    logic [8:0]          w_day_full;

    assign w_jan_feb  = (r10_mp >= gda_pkg::MP_JANUARY);
    assign w_day_full = r10_doy - gda_pkg::month_start(r10_mp) + 9'd1;
    assign w_year_u   = 17'({10'b0, r10_era} * 17'd400) + 17'(r10_yoe)
                      + 17'(w_jan_feb);
    assign w_year     = $signed(w_year_u) - gda_pkg::YEAR_REBASE;

    assign o_day          = w_day_full[4:0];
    assign o_month        = w_jan_feb ? (r10_mp - 4'd9) : (r10_mp + 4'd3);
    assign o_year         = w_year[13:0];
    assign o_out_of_range = (w_year < 17'sd1) || (w_year > 17'sd9999);

endmodule

/* sv/gregorian_date_arithmetic.sv */
// Proleptic Gregorian date unit. Each transfer in gives one transfer out, in order;
// one item is taken every cycle while the sink takes or any stage is empty. The
// depth follows the constant-divisor multiplies: three stages turn each date into a day
// number, one stage joins offset or difference, seven stages convert back to a
// date, and a final register holds the result. Empty stages close up under a
// stall, so input keeps flowing while a result waits as long as any stage is free.
// Command shift adds a signed offset to date A; command diff gives A minus B with
// ordering flags. Months saturate to 1..12 and out-of-month days count linearly.
// gregorian_date_arithmetic: top level, depends on gda_pkg, gda_pipe_ctrl,
// gda_day_number and gda_civil_date
module gregorian_date_arithmetic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic [gda_pkg::YEAR_W-1:0]          i_year_a,
    input  logic [gda_pkg::MONTH_W-1:0]         i_month_a,
    input  logic [gda_pkg::DAY_W-1:0]           i_day_a,
    input  logic signed [gda_pkg::OFFSET_W-1:0] i_offset,
    input  logic [gda_pkg::YEAR_W-1:0]          i_year_b,
    input  logic [gda_pkg::MONTH_W-1:0]         i_month_b,
    input  logic [gda_pkg::DAY_W-1:0]           i_day_b,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gda_pkg::YEAR_W-1:0]          o_result_year,
    output logic [gda_pkg::MONTH_W-1:0]         o_result_month,
    output logic [gda_pkg::DAY_W-1:0]           o_result_day,
    output logic signed [gda_pkg::DAYNUM_W-1:0] o_day_difference,
    output logic                                o_a_before_b,
    output logic                                o_a_equals_b,
    output logic                                o_out_of_range
);

    localparam int JS = gda_pkg::JOIN_STAGE;
    localparam int OS = gda_pkg::OUT_STAGE;

    logic [gda_pkg::NUM_STAGES-1:0]  w_load;
    logic [gda_pkg::DAYNUM_W-1:0]    w_dn_a, w_dn_b;
    logic [gda_pkg::YEAR_W-1:0]      w_civ_year;
    logic [gda_pkg::MONTH_W-1:0]     w_civ_month;
    logic [gda_pkg::DAY_W-1:0]       w_civ_day;
    logic                            w_civ_oor;

    // handshake and stage enables
    gda_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_load      (w_load)
    );

    // day numbers of both dates
    gda_day_number u_dn_a (
        .i_clk        (i_clk),
        .i_load       (w_load[gda_pkg::DN_STAGES-1:0]),
        .i_year       (i_year_a),
        .i_month      (i_month_a),
        .i_day        (i_day_a),
        .o_day_number (w_dn_a)
    );

    gda_day_number u_dn_b (
        .i_clk        (i_clk),
        .i_load       (w_load[gda_pkg::DN_STAGES-1:0]),
        .i_year       (i_year_b),
        .i_month      (i_month_b),
        .i_day        (i_day_b),
        .o_day_number (w_dn_b)
    );

    // command and offset travel beside the converters
    gda_pkg::t_command                  r_cmd [0:OS-1];
    logic signed [gda_pkg::OFFSET_W-1:0] r_off [0:JS-1];

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_cmd[0] <= gda_pkg::t_command'(i_command);
            r_off[0] <= i_offset;
        end
        for (int k = 1; k < OS; k++) begin
            if (w_load[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
        for (int k = 1; k < JS; k++) begin
            if (w_load[k]) begin
                r_off[k] <= r_off[k-1];
            end
        end
    end

    // join stage: biased shifted day number, difference and ordering
    logic signed [24:0]          w_z_full;
    logic signed [23:0]          w_diff_full;
    logic [gda_pkg::Z_W-1:0]     r_z;
    logic [gda_pkg::DAYNUM_W-1:0] r_diff [JS:OS-1];
    logic                        r_lt   [JS:OS-1];
    logic                        r_eq   [JS:OS-1];

    assign w_z_full    = $signed({2'b0, w_dn_a}) + 25'(r_off[JS-1])
                       + $signed({1'b0, gda_pkg::SHIFT_BASE});
    assign w_diff_full = $signed({1'b0, w_dn_a}) - $signed({1'b0, w_dn_b});

    always_ff @(posedge i_clk) begin
        if (w_load[JS]) begin
            r_z        <= w_z_full[gda_pkg::Z_W-1:0];
            r_diff[JS] <= w_diff_full[gda_pkg::DAYNUM_W-1:0];
            r_lt[JS]   <= (w_dn_a < w_dn_b);
            r_eq[JS]   <= (w_dn_a == w_dn_b);
        end
        for (int k = JS + 1; k < OS; k++) begin
            if (w_load[k]) begin
                r_diff[k] <= r_diff[k-1];
                r_lt[k]   <= r_lt[k-1];
                r_eq[k]   <= r_eq[k-1];
            end
        end
    end

    // back to a calendar date
    gda_civil_date u_civil (
        .i_clk          (i_clk),
        .i_load         (w_load[OS-1:JS+1]),
        .i_z            (r_z),
        .o_year         (w_civ_year),
        .o_month        (w_civ_month),
        .o_day          (w_civ_day),
        .o_out_of_range (w_civ_oor)
    );

    // output stage: pick the fields of the command, zero the rest
    logic [gda_pkg::YEAR_W-1:0]   n_year, r_year;
    logic [gda_pkg::MONTH_W-1:0]  n_month, r_month;
    logic [gda_pkg::DAY_W-1:0]    n_day, r_day;
    logic [gda_pkg::DAYNUM_W-1:0] n_diff, r_diff_out;
    logic                         n_lt, n_eq, n_oor, r_lt_out, r_eq_out, r_oor;

    always_comb begin
        n_year  = '0;
        n_month = '0;
        n_day   = '0;
        n_diff  = '0;
        n_lt    = 1'b0;
        n_eq    = 1'b0;
        n_oor   = 1'b0;
        unique case (r_cmd[OS-1])
            gda_pkg::CMD_SHIFT: begin
                n_year  = w_civ_year;
                n_month = w_civ_month;
                n_day   = w_civ_day;
                n_oor   = w_civ_oor;
            end
            gda_pkg::CMD_DIFF: begin
                n_diff = r_diff[OS-1];
                n_lt   = r_lt[OS-1];
                n_eq   = r_eq[OS-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load[OS]) begin
            r_year     <= n_year;
            r_month    <= n_month;
            r_day      <= n_day;
            r_diff_out <= n_diff;
            r_lt_out   <= n_lt;
            r_eq_out   <= n_eq;
            r_oor      <= n_oor;
        end
    end

    assign o_result_year    = r_year;
    assign o_result_month   = r_month;
    assign o_result_day     = r_day;
    assign o_day_difference = $signed(r_diff_out);
    assign o_a_before_b     = r_lt_out;
    assign o_a_equals_b     = r_eq_out;
    assign o_out_of_range   = r_oor;

endmodule
